// ===== sv/prc_pkg.sv =====
// constants shared by the point rotation pipeline: cordic angle table, gain factor,
// quadrant codes and angle-path widths
// no dependencies

package prc_pkg;

  // fraction bits added to the offset for the micro-rotations
  localparam int GUARD_BITS = 8;
  // angle accumulator width, 2^-32 turn units plus headroom
  localparam int ZW = 34;
  localparam int MAX_STAGES = 32;

  // fixed inverse cordic gain, 0.60725293500888 in q0.31
  localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;
  // half lsb of the q0.31 product
  localparam logic [30:0] GAIN_RND = 31'h4000_0000;
  // half lsb of the guard bits
  localparam logic [GUARD_BITS-1:0] GUARD_HALF = 8'h80;
  // one eighth turn in 16-bit binary angle units
  localparam logic [15:0] ANG_EIGHTH = 16'h2000;

  // quadrant codes, the angle's nearest multiple of a quarter turn
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [0:MAX_STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ===== sv/prc_cordic_stage.sv =====
// one registered cordic micro-rotation stage
// depends on prc_pkg for the angle table and accumulator width

module prc_cordic_stage
  import prc_pkg::*;
#(
  parameter int W   = 49,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [W-1:0]  x_r, x_nxt;
  logic signed [W-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [ZW-1:0] step;

  assign xs   = x_i >>> IDX;
  assign ys   = y_i >>> IDX;
  assign step = signed'({{(ZW-32){1'b0}}, ATAN_TURN[IDX]});

  always_comb begin
    // rotate toward zero residual angle
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - step;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== sv/point_rotate_about_center_top.sv =====
// point rotation about a pivot: quadrant fold, cordic micro-rotation chain,
// gain scale with rounding, pivot add with saturation
// depends on prc_pkg and prc_cordic_stage
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+-------------------------------------------
// in      | in  | in_tvalid/in_tready  | in_tdata: point_x, point_y, point_z,
//         |     |                      |   pivot_x, pivot_y, turn_angle
// out     | out | out_tvalid/out_tready| out_tdata: rotated_x, rotated_y, rotated_z
//         |     |                      | out_tuser: overflow
//
// one word accepted per cycle unless every stage holds a word and the output stalls;
// the pipeline depth grows with the chain of registered micro-rotation stages (capped at 32 stages)
// reset clears only the stage valid bits; the datapath carries no reset
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and the input keeps taking words while a result waits at the output

module point_rotate_about_center_top
  import prc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // point_x, point_y, point_z, pivot_x, pivot_y, turn_angle (low bits first)
  input  logic [((5*COORD_WIDTH+16+7)/8)*8-1:0]   in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // rotated_x, rotated_y, rotated_z (low bits first)
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  // overflow
  output logic [0:0]                              out_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int NC  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  // datapath width for the rotated offset, leaves room for growth and the gain split
  localparam int W   = CW + 17;
  localparam int HW  = W - 32;          // upper part of the magnitude for the gain split
  localparam int VW  = CW + 11;         // signed rounded offset
  localparam int SW  = 3 * CW;          // pivot and z side data
  localparam int ODW = ((3*CW+7)/8)*8;
  // stage indexes
  localparam int S_QUAD = 1;
  localparam int S_ABS  = NC + 2;
  localparam int S_MUL  = NC + 3;
  localparam int S_SUM  = NC + 4;
  localparam int S_RND  = NC + 5;
  localparam int NS     = NC + 7;

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // stage valid bits and the ready chain
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_r, v_nxt;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy_w;

  assign rdy_w[NS] = out_tready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy_w[k] = !v_r[k] || rdy_w[k+1];
  end

  assign v_in  = {v_r[NS-2:0], in_tvalid};
  assign v_nxt = (rdy_w[NS-1:0] & v_in) | (~rdy_w[NS-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy_w[0];
  assign out_tvalid = v_r[NS-1];

  // ---------------------------------------------------------------------------
  // input unpack
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] in_px, in_py, in_pz, in_cx, in_cy;
  logic [15:0]          in_ang;

  assign in_px  = in_tdata[CW-1:0];
  assign in_py  = in_tdata[2*CW-1:CW];
  assign in_pz  = in_tdata[3*CW-1:2*CW];
  assign in_cx  = in_tdata[4*CW-1:3*CW];
  assign in_cy  = in_tdata[5*CW-1:4*CW];
  assign in_ang = in_tdata[5*CW+15:5*CW];

  // pivot and z ride alongside the datapath: {z, pivot_y, pivot_x}
  logic [SW-1:0] side_r [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy_w[k]) begin
          side_r[k] <= {in_pz, in_cy, in_cx};
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rdy_w[k]) begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: offset from pivot, quadrant and residual angle
  // ---------------------------------------------------------------------------
  logic signed [CW:0]   dx_r, dx_nxt;
  logic signed [CW:0]   dy_r, dy_nxt;
  logic [1:0]           q_r, q_nxt;
  logic signed [15:0]   z0_r, z0_nxt;
  logic [15:0]          ang_wrap;

  always_comb begin
    dx_nxt   = {in_px[CW-1], in_px} - {in_cx[CW-1], in_cx};
    dy_nxt   = {in_py[CW-1], in_py} - {in_cy[CW-1], in_cy};
    ang_wrap = in_ang + ANG_EIGHTH;
    q_nxt    = ang_wrap[15:14];
    // residual in [-1/8, +1/8) turn, 16-bit wrap gives the sign directly
    z0_nxt   = signed'(in_ang - {q_nxt, 14'd0});
  end

  always_ff @(posedge clk) begin
    if (rdy_w[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      q_r  <= q_nxt;
      z0_r <= z0_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: guard bits and exact quarter-turn rotation
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  xe, ye;
  logic signed [W-1:0]  x1_r, x1_nxt;
  logic signed [W-1:0]  y1_r, y1_nxt;
  logic signed [ZW-1:0] z1_r, z1_nxt;

  always_comb begin
    xe     = {{(W-CW-1-GUARD_BITS){dx_r[CW]}}, dx_r, {GUARD_BITS{1'b0}}};
    ye     = {{(W-CW-1-GUARD_BITS){dy_r[CW]}}, dy_r, {GUARD_BITS{1'b0}}};
    z1_nxt = {{(ZW-32){z0_r[15]}}, z0_r, 16'd0};
    unique case (q_r)
      QUAD_0: begin
        x1_nxt = xe;
        y1_nxt = ye;
      end
      QUAD_1: begin
        x1_nxt = -ye;
        y1_nxt = xe;
      end
      QUAD_2: begin
        x1_nxt = -xe;
        y1_nxt = -ye;
      end
      QUAD_3: begin
        x1_nxt = ye;
        y1_nxt = -xe;
      end
      default: begin
        x1_nxt = xe;
        y1_nxt = ye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_w[S_QUAD]) begin
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      z1_r <= z1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // micro-rotation chain, one stage per register
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  xc_w [0:NC];
  logic signed [W-1:0]  yc_w [0:NC];
  logic signed [ZW-1:0] zc_w [0:NC];

  assign xc_w[0] = x1_r;
  assign yc_w[0] = y1_r;
  assign zc_w[0] = z1_r;

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    prc_cordic_stage #(
      .W   (W),
      .IDX (i)
    ) u_stage (
      .clk (clk),
      .en  (rdy_w[i+2]),
      .x_i (xc_w[i]),
      .y_i (yc_w[i]),
      .z_i (zc_w[i]),
      .x_o (xc_w[i+1]),
      .y_o (yc_w[i+1]),
      .z_o (zc_w[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // gain: magnitude, split product, sum with rounding, guard-bit rounding
  // rounding is half away from zero, so the work is done on magnitudes
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] xa_w, ya_w;
  logic [W-2:0]        mx_r, my_r;
  logic                nxa_r, nya_r, nxm_r, nym_r, nxs_r, nys_r;
  logic [HW+30:0]      phx_r, phy_r;
  logic [61:0]         plx_r, ply_r;
  logic [61:0]         plx_rnd, ply_rnd;
  logic [HW+31:0]      rx_r, ry_r;
  logic [HW+32:0]      rrx, rry;
  logic signed [VW-1:0] vx_r, vx_nxt, vy_r, vy_nxt;

  assign xa_w = xc_w[NC];
  assign ya_w = yc_w[NC];

  always_ff @(posedge clk) begin
    if (rdy_w[S_ABS]) begin
      nxa_r <= xa_w[W-1];
      nya_r <= ya_w[W-1];
      mx_r  <= xa_w[W-1] ? (W-1)'(-xa_w) : xa_w[W-2:0];
      my_r  <= ya_w[W-1] ? (W-1)'(-ya_w) : ya_w[W-2:0];
    end
  end

  // two partial products per coordinate: the upper HW bits and the lower 31 bits, each by the 31-bit gain
  always_ff @(posedge clk) begin
    if (rdy_w[S_MUL]) begin
      nxm_r <= nxa_r;
      nym_r <= nya_r;
      phx_r <= (HW+31)'(mx_r[W-2:31]) * (HW+31)'(INV_GAIN_Q31);
      phy_r <= (HW+31)'(my_r[W-2:31]) * (HW+31)'(INV_GAIN_Q31);
      plx_r <= 62'(mx_r[30:0]) * 62'(INV_GAIN_Q31);
      ply_r <= 62'(my_r[30:0]) * 62'(INV_GAIN_Q31);
    end
  end

  assign plx_rnd = plx_r + 62'(GAIN_RND);
  assign ply_rnd = ply_r + 62'(GAIN_RND);

  always_ff @(posedge clk) begin
    if (rdy_w[S_SUM]) begin
      nxs_r <= nxm_r;
      nys_r <= nym_r;
      rx_r  <= (HW+32)'(phx_r) + (HW+32)'(plx_rnd[61:31]);
      ry_r  <= (HW+32)'(phy_r) + (HW+32)'(ply_rnd[61:31]);
    end
  end

  always_comb begin
    rrx    = {1'b0, rx_r} + (HW+33)'(GUARD_HALF);
    rry    = {1'b0, ry_r} + (HW+33)'(GUARD_HALF);
    vx_nxt = nxs_r ? -signed'({1'b0, rrx[HW+32:GUARD_BITS]})
                   :  signed'({1'b0, rrx[HW+32:GUARD_BITS]});
    vy_nxt = nys_r ? -signed'({1'b0, rry[HW+32:GUARD_BITS]})
                   :  signed'({1'b0, rry[HW+32:GUARD_BITS]});
  end

  always_ff @(posedge clk) begin
    if (rdy_w[S_RND]) begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: add pivot back and saturate
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cx_w, cy_w;
  logic signed [CW+11:0] sx, sy;
  logic                  ovx, ovy;
  logic signed [CW-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic                  ovf_r, ovf_nxt;

  assign cx_w = side_r[S_RND][CW-1:0];
  assign cy_w = side_r[S_RND][2*CW-1:CW];

  always_comb begin
    sx  = {{12{cx_w[CW-1]}}, cx_w} + {vx_r[VW-1], vx_r};
    sy  = {{12{cy_w[CW-1]}}, cy_w} + {vy_r[VW-1], vy_r};
    // in range when every bit above the result's sign agrees with it
    ovx = !((&sx[CW+11:CW-1]) || !(|sx[CW+11:CW-1]));
    ovy = !((&sy[CW+11:CW-1]) || !(|sy[CW+11:CW-1]));
    ox_nxt  = ovx ? (sx[CW+11] ? MINV : MAXV) : sx[CW-1:0];
    oy_nxt  = ovy ? (sy[CW+11] ? MINV : MAXV) : sy[CW-1:0];
    ovf_nxt = ovx || ovy;
  end

  always_ff @(posedge clk) begin
    if (rdy_w[NS-1]) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_tdata = ODW'({side_r[NS-1][3*CW-1:2*CW], oy_r, ox_r});
  assign out_tuser = ovf_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // a saturated word must carry a limit value in x or y
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (ox_r == MAXV) || (ox_r == MINV) || (oy_r == MAXV) || (oy_r == MINV))
    else $error("overflow flag without a saturated coordinate");

  // input back-pressure only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled while the pipeline has a bubble");

  // residual angle after the quadrant fold stays within one eighth turn
  a_resid_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (&z0_r[15:13]) || !(|z0_r[15:13]))
    else $error("residual angle outside one eighth turn");
`endif

endmodule
